// ===== src/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg: shared types and codes for the priority scheduler
// Item and result records, the per-item classification and operation codes.
// ----------------------------------------------------------------------------
package pps_pkg;

  // Operation codes carried by the op field
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register map (word index)
  localparam logic REG_TASK_COUNT = 1'b0;
  localparam int   PADDR_W        = 3;

  // One input beat
  typedef struct packed {
    logic        op;
    logic [3:0]  slot;
    logic [7:0]  task_label;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  priority_req;
  } item_t;

  // Queue entry: the item plus what the front decoded from it
  typedef struct packed {
    item_t item;
    logic  is_tick;
    logic  slot_ok;
  } entry_t;

  // One result beat
  typedef struct packed {
    logic [15:0] tick_time;
    logic        running;
    logic [7:0]  run_label;
    logic        switched;
    logic        finished;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic        all_done;
  } result_t;

endpackage

// ===== src/pps_ram.sv =====
// ----------------------------------------------------------------------------
// pps_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pps_front.sv =====
// ----------------------------------------------------------------------------
// pps_front: input stage and command queue
// Takes input beats, decodes op and slot range, and holds them in a
// two-entry queue for the scheduling engine.
// ----------------------------------------------------------------------------
module pps_front #(
  parameter int MAX_TASKS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pps_pkg::item_t in_item_i,
  output logic           q_valid_o,
  output pps_pkg::entry_t q_entry_o,
  input  logic           q_pop_i
);
  import pps_pkg::*;

  entry_t     entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  entry_t     new_entry;

  // Classify the incoming item
  always_comb begin
    new_entry.item    = in_item_i;
    new_entry.is_tick = (in_item_i.op == OP_TICK);
    new_entry.slot_ok = (32'(in_item_i.slot) < MAX_TASKS);
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_entry_o  = entry_q[rd_ptr_q];

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_entry;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, q_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== src/pps_engine.sv =====
// ----------------------------------------------------------------------------
// pps_engine: task table and scheduling sequencer
// Executes loads into the task RAM, reporting state, and, per tick, scans the active
// slots one per cycle for the best ready task, updates it if found and emits the result.
// ----------------------------------------------------------------------------
module pps_engine #(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [4:0]       task_count_i,
  input  logic             q_valid_i,
  input  pps_pkg::entry_t  q_entry_i,
  output logic             q_pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output pps_pkg::result_t res_o
);
  import pps_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = ($clog2(MAX_TASKS + 1) > 5) ? $clog2(MAX_TASKS + 1) : 5;

  typedef struct packed {
    logic [7:0]           label;
    logic [TIME_BITS-1:0] arrival;
    logic [15:0]          burst;
    logic [15:0]          remain;
    logic [7:0]           prio;
  } rec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD
  } state_e;

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     cnt_q, cnt_d;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  rec_t                 best_q, best_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic                 last_valid_q, last_valid_d;
  logic [IDX_W-1:0]     last_slot_q, last_slot_d;
  logic [4:0]           compl_q, compl_d;
  logic                 res_valid_q, res_valid_d;
  result_t              res_q, res_d;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  rec_t                 ram_wdata, ram_rdata;

  logic [CNT_W-1:0]     n_active;
  logic                 out_free;

  // Active slot count, clamped to the table size
  assign n_active = (32'(task_count_i) > MAX_TASKS) ? CNT_W'(MAX_TASKS)
                                                   : CNT_W'(task_count_i);
  assign out_free = !res_valid_q || res_ready_i;

  pps_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer next-state logic
  always_comb begin
    rec_t                 load_rec;
    logic                 eligible;
    logic [TIME_BITS-1:0] time_nx;
    logic [15:0]          rem_nx;
    logic [TIME_BITS-1:0] tat;
    logic [31:0]          tat32, burst32;
    logic [4:0]           compl_nx;
    logic                 done_nx;

    state_d      = state_q;
    cnt_d        = cnt_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    time_d       = time_q;
    last_valid_d = last_valid_q;
    last_slot_d  = last_slot_q;
    compl_d      = compl_q;
    res_d        = res_q;
    res_valid_d  = res_valid_q && !res_ready_i;
    q_pop_o      = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = best_idx_q;
    ram_wdata    = best_q;
    ram_raddr    = cnt_q + IDX_W'(1);

    load_rec.label   = q_entry_i.item.task_label;
    load_rec.arrival = TIME_BITS'(q_entry_i.item.arrival);
    load_rec.burst   = q_entry_i.item.burst;
    load_rec.remain  = q_entry_i.item.burst;
    load_rec.prio    = q_entry_i.item.priority_req;

    eligible = (ram_rdata.arrival <= time_q) && (ram_rdata.remain != 16'd0) &&
               (!found_q || (ram_rdata.prio < best_q.prio));

    time_nx  = (time_q != {TIME_BITS{1'b1}}) ? time_q + TIME_BITS'(1) : time_q;
    rem_nx   = best_q.remain - 16'd1;
    tat      = time_nx - best_q.arrival;
    tat32    = 32'(tat);
    burst32  = 32'(best_q.burst);
    compl_nx = compl_q;
    if (found_q && (rem_nx == 16'd0) && (compl_q != 5'd31)) begin
      compl_nx = compl_q + 5'd1;
    end
    done_nx  = (CNT_W'(compl_nx) >= n_active);

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_entry_i.is_tick) begin
            // Start a tick: clear the best pick and begin reading slot 0
            q_pop_o   = 1'b1;
            found_d   = 1'b0;
            cnt_d     = '0;
            ram_raddr = '0;
            state_d   = (n_active == '0) ? ST_UPD : ST_SCAN;
          end else if (out_free) begin
            // Load: write the slot record if the slot is in range, report current state
            q_pop_o   = 1'b1;
            ram_we    = q_entry_i.slot_ok;
            ram_waddr = IDX_W'(q_entry_i.item.slot);
            ram_wdata = load_rec;
            res_d            = '0;
            res_d.tick_time  = 16'(time_q);
            res_d.all_done   = (CNT_W'(compl_q) >= n_active);
            res_valid_d      = 1'b1;
          end
        end
      end

      ST_SCAN: begin
        // Read data belongs to slot cnt_q
        if (eligible) begin
          found_d    = 1'b1;
          best_d     = ram_rdata;
          best_idx_d = cnt_q;
        end
        if ((CNT_W'(cnt_q) + CNT_W'(1)) == n_active) begin
          state_d = ST_UPD;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end

      ST_UPD: begin
        if (out_free) begin
          res_d           = '0;
          res_d.tick_time = 16'(time_q);
          time_d          = time_nx;
          if (found_q) begin
            // Run the picked task for one tick and write it back
            ram_we          = 1'b1;
            ram_waddr       = best_idx_q;
            ram_wdata       = best_q;
            ram_wdata.remain = rem_nx;
            res_d.running   = 1'b1;
            res_d.run_label = best_q.label;
            res_d.switched  = !last_valid_q || (last_slot_q != best_idx_q);
            last_valid_d    = 1'b1;
            last_slot_d     = best_idx_q;
            if (rem_nx == 16'd0) begin
              res_d.finished   = 1'b1;
              res_d.turnaround = tat32[15:0];
              res_d.waiting    = (tat32 >= burst32) ? 16'(tat32 - burst32) : 16'd0;
            end
          end
          compl_d        = compl_nx;
          res_d.all_done = done_nx;
          res_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      found_q      <= 1'b0;
      best_idx_q   <= '0;
      best_q       <= '0;
      time_q       <= '0;
      last_valid_q <= 1'b0;
      last_slot_q  <= '0;
      compl_q      <= '0;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      found_q      <= found_d;
      best_idx_q   <= best_idx_d;
      best_q       <= best_d;
      time_q       <= time_d;
      last_valid_q <= last_valid_d;
      last_slot_q  <= last_slot_d;
      compl_q      <= compl_d;
      res_valid_q  <= res_valid_d;
      res_q        <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== src/preemptive_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler: unit-time preemptive priority scheduler
// Loads task slots and, per tick, runs the ready task of best priority,
// reporting switches and completion times.
//
//   Channel   Signals                                    Direction
//   in        in_valid_i/in_ready_o, op_i .. priority_req_i  to block
//   out       out_valid_o/out_ready_i, tick_time_o .. all_done_o  from block
//   cfg       psel/penable/pwrite/paddr/pwdata/prdata/pready  APB slave
//
// A load is handled in the engine's idle state; a tick passes through the idle,
// scan and update states, the scan reading one active slot of the task RAM per cycle.
// A two-entry queue takes input beats while the engine works; the output
// register holds a result until taken and the engine stalls behind it.
// Reset clears time, counters and the last-run slot; the task RAM is not
// cleared and no pass runs after reset.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [3:0]                  slot_i,
  input  logic [7:0]                  task_label_i,
  input  logic [15:0]                 arrival_i,
  input  logic [15:0]                 burst_i,
  input  logic [7:0]                  priority_req_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [15:0]                 tick_time_o,
  output logic                        running_o,
  output logic [7:0]                  run_label_o,
  output logic                        switched_o,
  output logic                        finished_o,
  output logic [15:0]                 turnaround_o,
  output logic [15:0]                 waiting_o,
  output logic                        all_done_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pps_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import pps_pkg::*;

  logic [4:0] task_count_q;
  item_t      in_item;
  logic       q_valid, q_pop;
  entry_t     q_entry;
  result_t    res;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TASK_COUNT)) begin
      task_count_q <= pwdata[4:0];
    end
  end
  assign prdata = (paddr[2] == REG_TASK_COUNT) ? {27'd0, task_count_q} : 32'd0;

  // Pack input beat
  always_comb begin
    in_item.op           = op_i;
    in_item.slot         = slot_i;
    in_item.task_label   = task_label_i;
    in_item.arrival      = arrival_i;
    in_item.burst        = burst_i;
    in_item.priority_req = priority_req_i;
  end

  pps_front #(
    .MAX_TASKS (MAX_TASKS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  pps_engine #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .task_count_i (task_count_q),
    .q_valid_i    (q_valid),
    .q_entry_i    (q_entry),
    .q_pop_o      (q_pop),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (res)
  );

  // Unpack result beat
  assign tick_time_o  = res.tick_time;
  assign running_o    = res.running;
  assign run_label_o  = res.run_label;
  assign switched_o   = res.switched;
  assign finished_o   = res.finished;
  assign turnaround_o = res.turnaround;
  assign waiting_o    = res.waiting;
  assign all_done_o   = res.all_done;

endmodule
